FILE: rtl/i2cm_pkg.sv
`timescale 1ns / 1ps

package i2cm_pkg;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_READ  = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_STOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SUB_DATA = 2'd0,
    SUB_HIGH = 2'd1,
    SUB_LOW  = 2'd2
  } sub_e;

  localparam int unsigned PhaseW = 5;

  // Write: eight bits of three intervals each, then the acknowledge clock.
  localparam logic [PhaseW-1:0] WrAckRel  = 5'd24;
  localparam logic [PhaseW-1:0] WrAckHigh = 5'd25;
  localparam logic [PhaseW-1:0] WrLast    = 5'd26;

  // Read: eight bits of two intervals each, then the acknowledge from the master.
  localparam logic [PhaseW-1:0] RdAckDrv  = 5'd16;
  localparam logic [PhaseW-1:0] RdAckHigh = 5'd17;
  localparam logic [PhaseW-1:0] RdLast    = 5'd18;

  localparam logic [PhaseW-1:0] StSdaLow  = 5'd0;
  localparam logic [PhaseW-1:0] StSclHigh = 5'd1;
  localparam logic [PhaseW-1:0] StLast    = 5'd2;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       rejected;
  } res_t;

endpackage

FILE: rtl/i2cm_if.sv
`timescale 1ns / 1ps

interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] tx_byte;
  logic       ack_after;
  logic       sda_in;

  modport source (output valid, cmd, tx_byte, ack_after, sda_in, input ready);
  modport sink (input valid, cmd, tx_byte, ack_after, sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_drive;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       rejected;

  modport source (output valid, scl_level, sda_drive, sda_level, busy_res, done_res,
                  rx_byte, rejected, input ready);
  modport sink (input valid, scl_level, sda_drive, sda_level, busy_res, done_res,
                rx_byte, rejected, output ready);
endinterface

FILE: rtl/i2cm_core.sv
`timescale 1ns / 1ps

module i2cm_core
  import i2cm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [2:0] cmd_i,
  input  logic [7:0] tx_byte_i,
  input  logic       ack_after_i,
  input  logic       sda_in_i,
  output res_t       res_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  op_e               op_q, op_d;
  sub_e              sub_q, sub_d;
  logic [7:0]        shift_q, shift_d;
  logic              ack_q, ack_d;
  logic              active_q, active_d;
  logic              scl_q, scl_d;
  logic              drv_q, drv_d;
  logic              sda_q, sda_d;
  logic              last;
  logic              is_cmd;

  assign is_cmd = (cmd_i < CMD_TICK);

  always_comb begin
    phase_d  = phase_q;
    op_d     = op_q;
    sub_d    = sub_q;
    shift_d  = shift_q;
    ack_d    = ack_q;
    active_d = active_q;
    scl_d    = scl_q;
    drv_d    = drv_q;
    sda_d    = sda_q;
    last     = 1'b0;
    res_o    = '{scl_level: scl_q, sda_drive: drv_q, sda_level: sda_q,
                 busy_res: active_q, done_res: 1'b0, rx_byte: 8'd0, rejected: 1'b0};

    if (is_cmd) begin
      if (active_q) begin
        res_o.rejected = 1'b1;
      end else begin
        active_d       = 1'b1;
        op_d           = op_e'(cmd_i[1:0]);
        phase_d        = '0;
        sub_d          = SUB_DATA;
        shift_d        = (cmd_i == CMD_WRITE) ? tx_byte_i : 8'd0;
        ack_d          = ack_after_i;
        res_o.busy_res = 1'b1;
      end
    end else if (active_q) begin
      case (op_q)
        OP_START: begin
          if (phase_q == '0) begin
            scl_d = 1'b1;
            sda_d = 1'b0;
          end else begin
            scl_d = 1'b0;
          end
          last = 1'b1;
        end
        OP_WRITE: begin
          if (phase_q < WrAckRel) begin
            case (sub_q)
              SUB_DATA: begin
                sda_d = shift_q[7];
                sub_d = SUB_HIGH;
              end
              SUB_HIGH: begin
                scl_d = 1'b1;
                sub_d = SUB_LOW;
              end
              default: begin
                scl_d   = 1'b0;
                shift_d = {shift_q[6:0], 1'b0};
                sub_d   = SUB_DATA;
              end
            endcase
          end else if (phase_q == WrAckRel) begin
            drv_d = 1'b0;
          end else if (phase_q == WrAckHigh) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
          last = (phase_q >= WrLast);
        end
        OP_READ: begin
          if (phase_q < RdAckDrv) begin
            if (!phase_q[0]) begin
              drv_d   = 1'b0;
              scl_d   = 1'b1;
              shift_d = {shift_q[6:0], sda_in_i};
            end else begin
              scl_d = 1'b0;
            end
          end else if (phase_q == RdAckDrv) begin
            drv_d = 1'b1;
            sda_d = ~ack_q;
          end else if (phase_q == RdAckHigh) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
          last = (phase_q >= RdLast);
        end
        default: begin
          if (phase_q == StSdaLow) begin
            sda_d = 1'b0;
          end else if (phase_q == StSclHigh) begin
            scl_d = 1'b1;
          end else begin
            sda_d = 1'b1;
          end
          last = (phase_q >= StLast);
        end
      endcase

      res_o.scl_level = scl_d;
      res_o.sda_drive = drv_d;
      res_o.sda_level = sda_d;
      res_o.done_res  = last;
      res_o.rx_byte   = (last && op_q == OP_READ) ? shift_d : 8'd0;

      // The write releases SDA only for the acknowledge clock.
      if (op_q == OP_WRITE && last) begin
        drv_d = 1'b1;
      end
      if (last) begin
        active_d = 1'b0;
        phase_d  = '0;
      end else begin
        phase_d = phase_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      op_q     <= OP_START;
      sub_q    <= SUB_DATA;
      shift_q  <= '0;
      ack_q    <= 1'b0;
      active_q <= 1'b0;
      scl_q    <= 1'b1;
      drv_q    <= 1'b1;
      sda_q    <= 1'b1;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      op_q     <= op_d;
      sub_q    <= sub_d;
      shift_q  <= shift_d;
      ack_q    <= ack_d;
      active_q <= active_d;
      scl_q    <= scl_d;
      drv_q    <= drv_d;
      sda_q    <= sda_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q && op_q == OP_WRITE |-> phase_q <= WrLast)
    else $error("write sequence ran past its final interval");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q && op_q == OP_READ |-> phase_q <= RdLast)
    else $error("read sequence ran past its final interval");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> drv_q)
    else $error("SDA left released while idle");

endmodule

FILE: rtl/i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps

// Channel  Direction  Transaction
// in_i     sink       one command or one tick interval
// out_o    source     pin levels and status for that transaction
//
// Every input transaction yields one registered result, valid in the cycle after acceptance.
// A new transaction is taken in every cycle while the result register is empty or
// being emptied in the same cycle; the next-state logic is the only path.
// Reset leaves the sequencer idle with SCL high and SDA driven high.
// A stall on out_o holds the result and stops further input until it is taken.

module i2c_master_bit_sequencer
  import i2cm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  i2cm_in_if.sink    in_i,
  i2cm_out_if.source out_o
);

  logic out_vld_q;
  res_t res_d;
  res_t res_q;
  logic accept;

  assign in_i.ready = !out_vld_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  i2cm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (in_i.cmd),
    .tx_byte_i   (in_i.tx_byte),
    .ack_after_i (in_i.ack_after),
    .sda_in_i    (in_i.sda_in),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      out_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.scl_level = res_q.scl_level;
  assign out_o.sda_drive = res_q.sda_drive;
  assign out_o.sda_level = res_q.sda_level;
  assign out_o.busy_res  = res_q.busy_res;
  assign out_o.done_res  = res_q.done_res;
  assign out_o.rx_byte   = res_q.rx_byte;
  assign out_o.rejected  = res_q.rejected;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.done_res |-> res_q.busy_res && !res_q.rejected)
    else $error("completion reported outside a busy sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.rx_byte != 8'd0 |-> res_q.done_res)
    else $error("received byte shown before the read completed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_vld_q)
    else $error("accepted transaction produced no result");

endmodule

FILE: verif/i2cm_seq_checker.sv
`timescale 1ns / 1ps

module i2cm_seq_checker
  import i2cm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [2:0] cmd_i,
  input  logic [7:0] tx_byte_i,
  input  logic       ack_after_i,
  input  logic       sda_in_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  res_t       res_i,
  output int         fail_count_o,
  output int         pending_o
);

  logic [PhaseW-1:0] seq_phase;
  op_e               seq_op;
  logic [7:0]        seq_shift;
  logic              seq_ack;
  logic              seq_active;
  logic              pin_scl;
  logic              pin_sda_drv;
  logic              pin_sda;

  res_t expected_q[$];
  res_t predicted;
  res_t oldest;
  int   fail_count;

  task automatic advance_sequencer(input logic [2:0] cmd, input logic [7:0] tx,
                                   input logic ack, input logic sda_in,
                                   output res_t r);
    logic [PhaseW-1:0] p;
    logic              last;
    logic              stepped;
    int unsigned       bit_idx;
    sub_e              sub;
    r       = '0;
    p       = seq_phase;
    last    = 1'b0;
    stepped = 1'b0;
    if (cmd < CMD_TICK) begin
      if (seq_active) begin
        r.rejected = 1'b1;
      end else begin
        seq_active = 1'b1;
        seq_op     = op_e'(cmd[1:0]);
        seq_phase  = '0;
        seq_shift  = (cmd == CMD_WRITE) ? tx : 8'h00;
        seq_ack    = ack;
      end
      r.busy_res = 1'b1;
    end else if (seq_active) begin
      stepped = 1'b1;
      bit_idx = p / 3;
      sub     = sub_e'(p % 3);
      case (seq_op)
        OP_START: begin
          if (p == '0) begin
            pin_scl = 1'b1;
            pin_sda = 1'b0;
          end else begin
            pin_scl = 1'b0;
          end
          last = 1'b1;
        end
        OP_WRITE: begin
          if (p < WrAckRel) begin
            case (sub)
              SUB_DATA: pin_sda = seq_shift[7 - bit_idx];
              SUB_HIGH: pin_scl = 1'b1;
              default:  pin_scl = 1'b0;
            endcase
          end else if (p == WrAckRel) begin
            pin_sda_drv = 1'b0;
          end else if (p == WrAckHigh) begin
            pin_scl = 1'b1;
          end else begin
            pin_scl = 1'b0;
          end
          last = (p >= WrLast);
        end
        OP_READ: begin
          if (p < RdAckDrv) begin
            if (!p[0]) begin
              pin_sda_drv = 1'b0;
              pin_scl     = 1'b1;
              // The bit is taken from the same tick that drives SCL high.
              seq_shift   = {seq_shift[6:0], sda_in};
            end else begin
              pin_scl = 1'b0;
            end
          end else if (p == RdAckDrv) begin
            pin_sda_drv = 1'b1;
            pin_sda     = ~seq_ack;
          end else if (p == RdAckHigh) begin
            pin_scl = 1'b1;
          end else begin
            pin_scl = 1'b0;
          end
          last = (p >= RdLast);
        end
        default: begin
          if (p == StSdaLow) begin
            pin_sda = 1'b0;
          end else if (p == StSclHigh) begin
            pin_scl = 1'b1;
          end else begin
            pin_sda = 1'b1;
          end
          last = (p >= StLast);
        end
      endcase
      r.busy_res = 1'b1;
      r.done_res = last;
      r.rx_byte  = (last && seq_op == OP_READ) ? seq_shift : 8'h00;
    end
    r.scl_level = pin_scl;
    r.sda_drive = pin_sda_drv;
    r.sda_level = pin_sda;
    if (stepped) begin
      // SDA is taken back only once the acknowledge clock of a write is over.
      if (last && seq_op == OP_WRITE) begin
        pin_sda_drv = 1'b1;
      end
      if (last) begin
        seq_active = 1'b0;
        seq_phase  = '0;
      end else begin
        seq_phase = p + 1'b1;
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_phase    = '0;
      seq_op       = OP_START;
      seq_shift    = 8'h00;
      seq_ack      = 1'b0;
      seq_active   = 1'b0;
      pin_scl      = 1'b1;
      pin_sda_drv  = 1'b1;
      pin_sda      = 1'b1;
      fail_count   = 0;
      expected_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no expectation waiting");
          fail_count++;
        end else begin
          oldest = expected_q.pop_front();
          check_field("scl_level", oldest.scl_level, res_i.scl_level);
          check_field("sda_drive", oldest.sda_drive, res_i.sda_drive);
          check_field("sda_level", oldest.sda_level, res_i.sda_level);
          check_field("busy_res", oldest.busy_res, res_i.busy_res);
          check_field("done_res", oldest.done_res, res_i.done_res);
          check_field("rx_byte", oldest.rx_byte, res_i.rx_byte);
          check_field("rejected", oldest.rejected, res_i.rejected);
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_sequencer(cmd_i, tx_byte_i, ack_after_i, sda_in_i, predicted);
        expected_q.push_back(predicted);
      end
      fail_count_o <= fail_count;
      pending_o    <= expected_q.size();
    end
  end

endmodule

FILE: verif/i2c_master_bit_sequencer_tb.sv
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_tb;
  import i2cm_pkg::*;

  localparam logic [2:0]  CmdSpareLo    = 3'd5;
  localparam logic [2:0]  CmdSpareMid   = 3'd6;
  localparam logic [2:0]  CmdSpareHi    = 3'd7;
  localparam int unsigned RandomItems   = 1100;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned HoldOffCycles = 300;

  logic clk = 1'b0;
  logic rst_n;

  i2cm_in_if  in_if ();
  i2cm_out_if out_if ();

  int          fail_count;
  int          pending;
  int unsigned items_sent;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  bit          hold_off_req;
  int unsigned hold_left;

  always #10 clk = ~clk;

  i2c_master_bit_sequencer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  i2cm_seq_checker seq_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_if.valid),
    .in_ready_i   (in_if.ready),
    .cmd_i        (in_if.cmd),
    .tx_byte_i    (in_if.tx_byte),
    .ack_after_i  (in_if.ack_after),
    .sda_in_i     (in_if.sda_in),
    .out_valid_i  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .res_i        ({out_if.scl_level, out_if.sda_drive, out_if.sda_level,
                    out_if.busy_res, out_if.done_res, out_if.rx_byte,
                    out_if.rejected}),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("i2c_master_bit_sequencer: mismatch");
      $finish;
    end
  end

  // The receiver process owns the long hold-off once it has been requested.
  initial begin
    bit hold_taken;
    out_if.ready = 1'b0;
    hold_left    = 0;
    hold_taken   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic issue_transaction(input logic [2:0] cmd, input logic [7:0] tx,
                                   input logic ack, input logic sda);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.cmd       <= cmd;
    in_if.tx_byte   <= tx;
    in_if.ack_after <= ack;
    in_if.sda_in    <= sda;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_tick(input logic sda);
    logic [2:0] code;
    code = ($urandom_range(3) == 0) ? 3'($urandom_range(CmdSpareHi, CMD_TICK)) : CMD_TICK;
    issue_transaction(code, 8'($urandom_range(255)), 1'($urandom_range(1)), sda);
  endtask

  task automatic run_sequence();
    logic [2:0]  cmd;
    logic [7:0]  tx;
    logic        sda;
    int unsigned ticks;
    int unsigned sda_mode;
    cmd = 3'($urandom_range(CMD_STOP));
    case (cmd)
      CMD_START: ticks = 2;
      CMD_WRITE: ticks = 27;
      CMD_READ:  ticks = 19;
      default:   ticks = 3;
    endcase
    case ($urandom_range(3))
      0:       tx = 8'h00;
      1:       tx = 8'hFF;
      default: tx = 8'($urandom_range(255));
    endcase
    sda_mode = $urandom_range(3);
    if ($urandom_range(99) < 8) begin
      send_tick(1'($urandom_range(1)));
    end
    issue_transaction(cmd, tx, 1'($urandom_range(1)), 1'($urandom_range(1)));
    for (int unsigned i = 0; i < ticks; i++) begin
      if ($urandom_range(99) < 4) begin
        issue_transaction(3'($urandom_range(CMD_STOP)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      if ($urandom_range(99) >= 2) begin
        case (sda_mode)
          0:       sda = 1'b0;
          1:       sda = 1'b1;
          default: sda = 1'($urandom_range(1));
        endcase
        send_tick(sda);
      end
    end
  endtask

  initial begin
    int unsigned phase_idx;
    int unsigned target;
    in_if.valid     = 1'b0;
    in_if.cmd       = CMD_TICK;
    in_if.tx_byte   = 8'h00;
    in_if.ack_after = 1'b0;
    in_if.sda_in    = 1'b0;
    rst_n           = 1'b0;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    hold_off_req    = 1'b0;
    items_sent      = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    issue_transaction(CMD_TICK, 8'h00, 1'b0, 1'b0);
    issue_transaction(CmdSpareLo, 8'hFF, 1'b1, 1'b1);
    issue_transaction(CmdSpareMid, 8'h00, 1'b0, 1'b1);
    issue_transaction(CmdSpareHi, 8'hFF, 1'b1, 1'b0);
    issue_transaction(CMD_START, 8'hFF, 1'b1, 1'b1);
    issue_transaction(CMD_WRITE, 8'hA5, 1'b0, 1'b0);
    issue_transaction(CMD_TICK, 8'h00, 1'b0, 1'b0);
    issue_transaction(CmdSpareHi, 8'h00, 1'b0, 1'b1);
    issue_transaction(CMD_STOP, 8'h00, 1'b0, 1'b0);
    issue_transaction(CMD_READ, 8'h00, 1'b1, 1'b1);
    issue_transaction(CMD_STOP, 8'hFF, 1'b0, 1'b0);
    issue_transaction(CMD_TICK, 8'h00, 1'b0, 1'b1);
    issue_transaction(CmdSpareLo, 8'h00, 1'b0, 1'b0);
    issue_transaction(CmdSpareMid, 8'h00, 1'b0, 1'b1);
    issue_transaction(CMD_START, 8'h00, 1'b0, 1'b0);
    issue_transaction(CMD_START, 8'h00, 1'b1, 1'b0);
    issue_transaction(CMD_TICK, 8'h00, 1'b0, 1'b0);
    issue_transaction(CMD_TICK, 8'h00, 1'b0, 1'b0);

    for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
      case (phase_idx)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 66;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 66;
        end
        default: begin
          src_idle_pct   = 27;
          sink_stall_pct = 27;
        end
      endcase
      if (phase_idx == 0) begin
        hold_off_req = 1'b1;
        repeat (20) send_tick(1'($urandom_range(1)));
      end
      if (phase_idx == 2) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      target = items_sent + RandomItems / 4;
      while (items_sent < target) run_sequence();
    end

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("i2c_master_bit_sequencer: match");
    end else begin
      $display("i2c_master_bit_sequencer: mismatch");
    end
    $finish;
  end

endmodule
